### rtl/core/fees_pkg.sv
// Shared types and constants for the Frank elastic energy stencil.
package fees_pkg;

  // Fraction bits of a director component.
  localparam int unsigned DIR_FRAC = 14;

  typedef struct packed {
    logic signed [15:0] order_value;
    logic signed [15:0] dir_z;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_x;
  } fees_in_t;

  typedef struct packed {
    logic [31:0] splay_energy;
    logic [31:0] twist_energy;
    logic [31:0] bend_energy;
    logic [31:0] curl_energy;
    logic        last_point;
  } fees_out_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X    = 3'd0,
    REG_SIZE_Y    = 3'd1,
    REG_SIZE_Z    = 3'd2,
    REG_THRESHOLD = 3'd3,
    REG_CHIRAL    = 3'd4
  } fees_reg_t;

  // Control flags of one arriving point, handed from the address unit to the datapath.
  typedef struct packed {
    logic emit;
    logic last;
  } fees_ctl_t;

endpackage

### rtl/core/frank_elastic_energy_stencil.sv
// Frank elastic energy stencil: one grid point per cycle unless the output stalls.
// Points stream in raster order, x fastest. The block takes one point every cycle while the
// output side keeps up; a ring store with six registered read ports and a six-stage
// datapath set that rate. A result (splay, twist, bend and curl-squared of the point one
// plane back) follows each accepted point with z of two or more, once it has passed the
// ring read registers and the six datapath stages. The pipeline advances only when the
// output register is empty or being taken, so a stalled output stalls input intake.
module frank_elastic_energy_stencil
  import fees_pkg::*;
#(
  parameter int unsigned MAX_X = 256,
  parameter int unsigned MAX_Y = 256,
  parameter int unsigned MAX_Z = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fees_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fees_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned XW = $clog2(MAX_X);
  localparam int unsigned YW = $clog2(MAX_Y);
  localparam int unsigned PLANE = MAX_X * MAX_Y;
  localparam int unsigned AW = $clog2(3 * PLANE);
  localparam int unsigned LAT = 7;

  logic [8:0]  size_x_r, size_y_r;
  logic [10:0] size_z_r;
  logic signed [15:0] thresh_r, chiral_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= 9'd256;
      size_y_r <= 9'd256;
      size_z_r <= 11'd1024;
      thresh_r <= 16'sd2048;
      chiral_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE_X:    size_x_r <= cfg_data[8:0];
        REG_SIZE_Y:    size_y_r <= cfg_data[8:0];
        REG_SIZE_Z:    size_z_r <= cfg_data[10:0];
        REG_THRESHOLD: thresh_r <= cfg_data;
        REG_CHIRAL:    chiral_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [12:0] clampsz(input logic [12:0] v, input logic [12:0] top);
    if (v < 13'd3) return 13'd3;
    if (v > top) return top;
    return v;
  endfunction

  logic [12:0] sx, sy, sz;
  assign sx = clampsz(13'(size_x_r), 13'(MAX_X));
  assign sy = clampsz(13'(size_y_r), 13'(MAX_Y));
  assign sz = clampsz(13'(size_z_r), 13'(MAX_Z));

  // Position and ring slot of the next arrival.
  logic [12:0] px_r, py_r, pz_r;
  logic [1:0]  slot_r;
  logic        adv;
  logic [LAT-1:0] vld_r;
  logic        stall;

  assign stall = out_valid && !out_ready;
  assign adv = !stall;
  assign in_ready = adv;

  logic acc;
  assign acc = in_valid && in_ready;

  logic xe, ye, ze;
  assign xe = px_r + 13'd1 >= sx;
  assign ye = py_r + 13'd1 >= sy;
  assign ze = pz_r + 13'd1 >= sz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0; py_r <= '0; pz_r <= '0; slot_r <= '0;
    end else if (acc) begin
      px_r <= xe ? '0 : px_r + 13'd1;
      if (xe) begin
        py_r <= ye ? '0 : py_r + 13'd1;
        if (ye) begin
          pz_r   <= ze ? '0 : pz_r + 13'd1;
          slot_r <= (ze || slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
        end
      end
    end
  end

  // Slot of the centre plane and of the one below it.
  logic [1:0] sc, sb;
  assign sc = (slot_r == 2'd0) ? 2'd2 : slot_r - 2'd1;
  assign sb = (sc == 2'd0) ? 2'd2 : sc - 2'd1;

  function automatic logic [AW-1:0] ra(input logic [1:0] s, input logic [12:0] x,
                                       input logic [12:0] y);
    return AW'(s) * AW'(PLANE) + AW'(y[YW-1:0]) * AW'(MAX_X) + AW'(x[XW-1:0]);
  endfunction

  logic [12:0] xm, xp, ym, yp;
  assign xm = (px_r == 0) ? sx - 13'd1 : px_r - 13'd1;
  assign xp = xe ? '0 : px_r + 13'd1;
  assign ym = (py_r == 0) ? sy - 13'd1 : py_r - 13'd1;
  assign yp = ye ? '0 : py_r + 13'd1;

  logic [6:0][AW-1:0] rd_addr;
  assign rd_addr[0] = ra(sc, px_r, py_r);
  assign rd_addr[1] = ra(sc, xm, py_r);
  assign rd_addr[2] = ra(sc, xp, py_r);
  assign rd_addr[3] = ra(sc, px_r, ym);
  assign rd_addr[4] = ra(sc, px_r, yp);
  assign rd_addr[5] = ra(sb, px_r, py_r);
  assign rd_addr[6] = ra(slot_r, px_r, py_r);

  logic [5:0][63:0] rd_data;
  logic [6:0][63:0] words;
  logic [63:0] in_word_r;

  fees_ring #(.AW(AW), .DEPTH(3 * PLANE)) u_ring (
    .clk     (clk),
    .wr_en   (acc),
    .wr_addr (rd_addr[6]),
    .wr_data (in_data),
    .rd_en   (adv),
    .rd_addr (rd_addr[5:0]),
    .rd_data (rd_data)
  );

  // The above-plane neighbour is the arriving point itself: take it from the input.
  always_ff @(posedge clk) begin
    if (adv) in_word_r <= in_data;
  end
  assign words = {in_word_r, rd_data};

  fees_ctl_t ctl, ctl_r;
  assign ctl.emit = acc && (pz_r >= 13'd2);
  assign ctl.last = xe && ye && ze;

  always_ff @(posedge clk) begin
    if (adv) ctl_r <= ctl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LAT-2:0], ctl.emit};
  end

  fees_calc u_calc (
    .clk     (clk),
    .en      (adv),
    .words   (words),
    .thresh  (thresh_r),
    .chiral  (chiral_r),
    .last_in (ctl_r.last),
    .res     (out_data)
  );

  assign out_valid = vld_r[LAT-1];

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r != 2'd3)
    else $error("ring slot out of range");
`endif

endmodule

### rtl/core/fees_ring.sv
// Three-plane ring store: one write port and six read ports, each read registered.
module fees_ring
  import fees_pkg::*;
#(
  parameter int unsigned AW = 18,
  parameter int unsigned DEPTH = 196608
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [63:0]      wr_data,
  input  logic             rd_en,
  input  logic [5:0][AW-1:0] rd_addr,
  output logic [5:0][63:0] rd_data
);

  // Each read port is its own copy of the store, all written alike.
  for (genvar p = 0; p < 6; p++) begin : g_bank
    logic [63:0] mem [DEPTH];
    logic [63:0] q_r;
    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        q_r <= mem[rd_addr[p]];
      end
    end
    assign rd_data[p] = q_r;
  end

endmodule

### rtl/core/fees_calc.sv
// Pipelined energy datapath: neighbour flip, differences, curl, products and saturation.
module fees_calc
  import fees_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [6:0][63:0]   words,
  input  logic signed [15:0] thresh,
  input  logic signed [15:0] chiral,
  input  logic               last_in,
  output fees_out_t          res
);

  localparam int unsigned FS = 2 * DIR_FRAC + 2;
  localparam int unsigned FB = 4 * DIR_FRAC + 2;

  function automatic logic [31:0] sat_out(input logic [127:0] v, input int unsigned frac);
    logic [127:0] s;
    s = (frac >= 28) ? (v >> (frac - 28)) : (v << (28 - frac));
    if (frac < 28 && (v >> (32 - (28 - frac))) != '0) return 32'hFFFF_FFFF;
    if (s[127:32] != '0) return 32'hFFFF_FFFF;
    return s[31:0];
  endfunction

  // Stage 1: dot products of each neighbour with the centre.
  logic signed [15:0] c_r [3];
  logic signed [15:0] nb_r [6][3];
  logic signed [33:0] dot_r [6];
  logic ok1_r, last1_r;
  logic signed [15:0] ch1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 3; n++) c_r[n] <= $signed(words[0][16*n +: 16]);
      for (int i = 0; i < 6; i++) begin
        for (int n = 0; n < 3; n++) nb_r[i][n] <= $signed(words[i+1][16*n +: 16]);
        dot_r[i] <= 34'(
          $signed(words[0][15:0])  * $signed(words[i+1][15:0]))  + 34'(
          $signed(words[0][31:16]) * $signed(words[i+1][31:16])) + 34'(
          $signed(words[0][47:32]) * $signed(words[i+1][47:32]));
      end
      ok1_r   <= $signed(words[0][63:48]) >= thresh;
      last1_r <= last_in;
      ch1_r   <= chiral;
    end
  end

  // Stage 2: flip, differences, divergence and curl.
  logic signed [17:0] d [3][3];
  logic signed [19:0] dv_r, cu_r [3];
  logic signed [15:0] c2_r [3];
  logic ok2_r, last2_r;
  logic signed [15:0] ch2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int n = 0; n < 3; n++) begin
        d[i][n] = (dot_r[2*i+1] < 0 ? -18'(nb_r[2*i+1][n]) : 18'(nb_r[2*i+1][n]))
                - (dot_r[2*i] < 0 ? -18'(nb_r[2*i][n]) : 18'(nb_r[2*i][n]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r     <= 20'(d[0][0]) + 20'(d[1][1]) + 20'(d[2][2]);
      cu_r[0]  <= 20'(d[1][2]) - 20'(d[2][1]);
      cu_r[1]  <= 20'(d[2][0]) - 20'(d[0][2]);
      cu_r[2]  <= 20'(d[0][1]) - 20'(d[1][0]);
      c2_r     <= c_r;
      ok2_r    <= ok1_r;
      last2_r  <= last1_r;
      ch2_r    <= ch1_r;
    end
  end

  // Stage 3: twist, bend vector, and the plain squares.
  logic signed [39:0] tw_r, bv_r [3];
  logic [39:0] sdv_r, scu_r;
  logic ok3_r, last3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tw_r <= 40'(c2_r[0]) * 40'(cu_r[0]) + 40'(c2_r[1]) * 40'(cu_r[1])
            + 40'(c2_r[2]) * 40'(cu_r[2]) + (40'(ch2_r) <<< (2 * DIR_FRAC - 13));
      bv_r[0] <= 40'(c2_r[1]) * 40'(cu_r[2]) - 40'(c2_r[2]) * 40'(cu_r[1]);
      bv_r[1] <= 40'(c2_r[2]) * 40'(cu_r[0]) - 40'(c2_r[0]) * 40'(cu_r[2]);
      bv_r[2] <= 40'(c2_r[0]) * 40'(cu_r[1]) - 40'(c2_r[1]) * 40'(cu_r[0]);
      sdv_r <= 40'(dv_r) * 40'(dv_r);
      scu_r <= 40'(cu_r[0]) * 40'(cu_r[0]) + 40'(cu_r[1]) * 40'(cu_r[1])
             + 40'(cu_r[2]) * 40'(cu_r[2]);
      ok3_r   <= ok2_r;
      last3_r <= last2_r;
    end
  end

  // Stage 4: magnitudes of the wide terms.
  logic [39:0] mtw_r, mbv_r [3];
  logic [39:0] sdv4_r, scu4_r;
  logic ok4_r, last4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mtw_r <= tw_r[39] ? 40'(-tw_r) : 40'(tw_r);
      for (int n = 0; n < 3; n++) mbv_r[n] <= bv_r[n][39] ? 40'(-bv_r[n]) : 40'(bv_r[n]);
      sdv4_r  <= sdv_r;
      scu4_r  <= scu_r;
      ok4_r   <= ok3_r;
      last4_r <= last3_r;
    end
  end

  // Stage 5: squares of the wide terms, split into 20-bit halves.
  logic [79:0] ptw_r, pbv_r [3];
  logic [39:0] sdv5_r, scu5_r;
  logic ok5_r, last5_r;

  function automatic logic [79:0] sq40(input logic [39:0] a);
    logic [39:0] ll, lh, hh;
    ll = 40'(a[19:0]) * 40'(a[19:0]);
    lh = 40'(a[19:0]) * 40'(a[39:20]);
    hh = 40'(a[39:20]) * 40'(a[39:20]);
    return 80'(ll) + (80'(lh) << 21) + (80'(hh) << 40);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      ptw_r <= sq40(mtw_r);
      for (int n = 0; n < 3; n++) pbv_r[n] <= sq40(mbv_r[n]);
      sdv5_r  <= sdv4_r;
      scu5_r  <= scu4_r;
      ok5_r   <= ok4_r;
      last5_r <= last4_r;
    end
  end

  // Stage 6: scale, saturate, and apply the order gate.
  logic [81:0] bsum;
  assign bsum = 82'(pbv_r[0]) + 82'(pbv_r[1]) + 82'(pbv_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      res.splay_energy <= ok5_r ? sat_out(128'(sdv5_r), FS) : '0;
      res.curl_energy  <= ok5_r ? sat_out(128'(scu5_r), FS) : '0;
      res.twist_energy <= ok5_r ? sat_out(128'(ptw_r), FB) : '0;
      res.bend_energy  <= ok5_r ? sat_out(128'(bsum), FB) : '0;
      res.last_point   <= last5_r;
    end
  end

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the Frank elastic energy stencil.
`timescale 1ns / 1ps

module tb;
  import fees_pkg::*;

  localparam int unsigned RING_PLANE = 256 * 256;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fees_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fees_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SIZE_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  frank_elastic_energy_stencil dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the block's state.
  logic [63:0] plane_store [0:3*RING_PLANE-1];
  int unsigned grid_x, grid_y, grid_z;
  logic [8:0] reg_size_x, reg_size_y;
  logic [10:0] reg_size_z;
  logic signed [15:0] reg_threshold, reg_chiral;

  fees_out_t energy_queue[$];
  int errors = 0;
  bit calm = 1'b0;
  int out_stall = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned top);
    if (v < 3) return 3;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int unsigned store_addr(int unsigned slot, int unsigned x, int unsigned y);
    return (slot % 3) * RING_PLANE + (y % 256) * 256 + (x % 256);
  endfunction

  function automatic logic [127:0] square_mag(longint s);
    logic [127:0] a;
    a = (s < 0) ? 128'(-s) : 128'(s);
    return a * a;
  endfunction

  function automatic logic [31:0] scale_sat(logic [127:0] v, int sh);
    logic [127:0] r;
    r = v >> sh;
    return (r > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  // Advances the shadow state by one point; returns 1 when a result is due.
  function automatic bit predict_energies(fees_in_t pt, output fees_out_t res);
    int unsigned sx, sy, sz, x, y, z, k, xm, xp, ym, yp;
    longint c[4], nb[6][3], d[3][3], cu[3], bv[3], dv, tw, p;
    logic [63:0] w;
    bit emit;
    sx = clamp_dim(reg_size_x, 256);
    sy = clamp_dim(reg_size_y, 256);
    sz = clamp_dim(reg_size_z, 1024);
    x = grid_x; y = grid_y; z = grid_z;
    res = '0;
    res.last_point = (x + 1 >= sx) && (y + 1 >= sy) && (z + 1 >= sz);
    plane_store[store_addr(z, x, y)] = pt;
    emit = (z >= 2);
    if (emit) begin
      k = z - 1;
      xm = (x == 0) ? sx - 1 : x - 1;
      xp = (x + 1 >= sx) ? 0 : x + 1;
      ym = (y == 0) ? sy - 1 : y - 1;
      yp = (y + 1 >= sy) ? 0 : y + 1;
      w = plane_store[store_addr(k, x, y)];
      for (int i = 0; i < 4; i++) c[i] = longint'($signed(w[16*i +: 16]));
      if (c[3] >= longint'(reg_threshold)) begin
        for (int i = 0; i < 6; i++) begin
          case (i)
            0: w = plane_store[store_addr(k, xm, y)];
            1: w = plane_store[store_addr(k, xp, y)];
            2: w = plane_store[store_addr(k, x, ym)];
            3: w = plane_store[store_addr(k, x, yp)];
            4: w = plane_store[store_addr(k - 1, x, y)];
            default: w = plane_store[store_addr(z, x, y)];
          endcase
          for (int n = 0; n < 3; n++) nb[i][n] = longint'($signed(w[16*n +: 16]));
          p = c[0] * nb[i][0] + c[1] * nb[i][1] + c[2] * nb[i][2];
          if (p < 0) for (int n = 0; n < 3; n++) nb[i][n] = -nb[i][n];
        end
        for (int i = 0; i < 3; i++)
          for (int n = 0; n < 3; n++) d[i][n] = nb[2*i+1][n] - nb[2*i][n];
        dv = d[0][0] + d[1][1] + d[2][2];
        cu[0] = d[1][2] - d[2][1];
        cu[1] = d[2][0] - d[0][2];
        cu[2] = d[0][1] - d[1][0];
        tw = c[0] * cu[0] + c[1] * cu[1] + c[2] * cu[2] + longint'(reg_chiral) * 32768;
        bv[0] = c[1] * cu[2] - c[2] * cu[1];
        bv[1] = c[2] * cu[0] - c[0] * cu[2];
        bv[2] = c[0] * cu[1] - c[1] * cu[0];
        // Differences carry 15 fraction bits, products with the centre 29.
        res.splay_energy = scale_sat(square_mag(dv), 2);
        res.twist_energy = scale_sat(square_mag(tw), 30);
        res.bend_energy = scale_sat(square_mag(bv[0]) + square_mag(bv[1]) + square_mag(bv[2]), 30);
        res.curl_energy = scale_sat(square_mag(cu[0]) + square_mag(cu[1]) + square_mag(cu[2]), 2);
      end
    end
    if (x + 1 >= sx) begin
      grid_x = 0;
      if (y + 1 >= sy) begin
        grid_y = 0;
        grid_z = (z + 1 >= sz) ? 0 : z + 1;
      end else begin
        grid_y = y + 1;
      end
    end else begin
      grid_x = x + 1;
    end
    return emit;
  endfunction

  task automatic write_reg(fees_reg_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_SIZE_X: reg_size_x = val[8:0];
      REG_SIZE_Y: reg_size_y = val[8:0];
      REG_SIZE_Z: reg_size_z = val[10:0];
      REG_THRESHOLD: reg_threshold = val;
      default: reg_chiral = val;
    endcase
  endtask

  task automatic configure(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                           logic [15:0] thr, logic [15:0] chi);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_CHIRAL, chi);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 3) return $urandom_range(30, 10);
    if (r < 25) return $urandom_range(3, 1);
    return 0;
  endfunction

  // Sends one point; typed_zero replaces the prediction by a known all-zero result.
  task automatic send_point(fees_in_t pt, bit typed_zero);
    fees_out_t res;
    int unsigned gap;
    in_valid <= 1'b1;
    in_data <= pt;
    do @(posedge clk); while (!in_ready);
    if (predict_energies(pt, res)) begin
      if (typed_zero) begin
        if (res.splay_energy != 0 || res.twist_energy != 0 ||
            res.bend_energy != 0 || res.curl_energy != 0) begin
          $error("directed row: centre was expected below threshold");
          errors++;
        end
        res = '{default: '0, last_point: res.last_point};
      end
      energy_queue.push_back(res);
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (energy_queue.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(32768) - 16384);
  endfunction

  task automatic send_grid(int unsigned n);
    fees_in_t pt;
    for (int unsigned i = 0; i < n; i++) begin
      pt.dir_x = rand_comp();
      pt.dir_y = rand_comp();
      pt.dir_z = rand_comp();
      pt.order_value = 16'($urandom);
      send_point(pt, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (energy_queue.size() == 0) begin
        $error("result with no expectation pending");
        errors++;
      end else begin
        fees_out_t e;
        e = energy_queue.pop_front();
        if (out_data.splay_energy != e.splay_energy) begin
          $error("splay_energy: expected %h, got %h", e.splay_energy, out_data.splay_energy);
          errors++;
        end
        if (out_data.twist_energy != e.twist_energy) begin
          $error("twist_energy: expected %h, got %h", e.twist_energy, out_data.twist_energy);
          errors++;
        end
        if (out_data.bend_energy != e.bend_energy) begin
          $error("bend_energy: expected %h, got %h", e.bend_energy, out_data.bend_energy);
          errors++;
        end
        if (out_data.curl_energy != e.curl_energy) begin
          $error("curl_energy: expected %h, got %h", e.curl_energy, out_data.curl_energy);
          errors++;
        end
        if (out_data.last_point != e.last_point) begin
          $error("last_point: expected %b, got %b", e.last_point, out_data.last_point);
          errors++;
        end
      end
    end
    if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(99) < 20)
        out_stall = ($urandom_range(99) < 10) ? $urandom_range(30, 10) : $urandom_range(3, 1);
    end
  end

  typedef struct {
    logic signed [15:0] dx, dy, dz, ord;
    bit zero_exp;
  } stim_row_t;

  // A 3x3x3 grid: extreme components in the first plane, low-order centres in the
  // middle plane, opposite and orthogonal neighbours around them.
  stim_row_t stim_table [27] = '{
    '{16384, 0, 0, 32767, 0}, '{-16384, 0, 0, 32767, 0}, '{0, 16384, 0, 1, 0},
    '{0, 0, -16384, 2, 0}, '{32767, -32768, 32767, -32768, 0}, '{-32768, -32768, -32768, 0, 0},
    '{16384, 16384, 16384, 1, 0}, '{0, 0, 0, 5, 0}, '{11585, 11585, 0, 100, 0},
    '{16384, 0, 0, -1, 0}, '{-16384, 0, 0, 0, 0}, '{0, 16384, 0, -32768, 0},
    '{0, -16384, 0, 32767, 0}, '{16384, 0, 0, 8192, 0}, '{-11585, 11585, 0, -2, 0},
    '{0, 0, 16384, 8192, 0}, '{-16384, 0, 0, 4000, 0}, '{9459, -9459, 9459, 16384, 0},
    '{-16384, 0, 0, 3, 1}, '{16384, 0, 0, 3, 0}, '{0, 0, 16384, 3, 1},
    '{0, 16384, 0, 3, 0}, '{-16384, 0, 0, 3, 0}, '{16384, 16384, 0, 3, 1},
    '{0, 0, -16384, 3, 0}, '{32767, 32767, 32767, 3, 0}, '{-32768, 0, 16384, 3, 0}
  };

  initial begin
    fees_in_t pt;
    int unsigned sent;
    grid_x = 0; grid_y = 0; grid_z = 0;
    reg_size_x = 256; reg_size_y = 256; reg_size_z = 1024;
    reg_threshold = 2048; reg_chiral = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sizes below the minimum clamp to three.
    configure(16'd0, 16'd1, 16'd2, 16'd0, 16'd0);
    foreach (stim_table[i]) begin
      pt.dir_x = stim_table[i].dx;
      pt.dir_y = stim_table[i].dy;
      pt.dir_z = stim_table[i].dz;
      pt.order_value = stim_table[i].ord;
      send_point(pt, stim_table[i].zero_exp);
    end
    drain();

    // Long rows, tall columns and deep stacks, one whole grid each.
    configure(16'd32, 16'd3, 16'd3, 16'h8000, 16'd16384);
    send_grid(32 * 9);
    drain();
    calm = 1'b1;
    configure(16'd3, 16'd20, 16'd3, 16'h7FFF, 16'hC000);
    send_grid(20 * 9);
    drain();
    calm = 1'b0;
    configure(16'd3, 16'd3, 16'd12, 16'd2048, 16'hFFFF);
    send_grid(9 * 12);
    drain();

    sent = 0;
    while (sent < 100) begin
      int unsigned sx, sy, sz;
      sx = $urandom_range(6, 3);
      sy = $urandom_range(6, 3);
      sz = $urandom_range(5, 3);
      calm = ($urandom_range(4) == 0);
      configure(16'(sx), 16'(sy), 16'(sz),
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4096)),
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(32768) - 16384));
      send_grid(sx * sy * sz);
      sent += sx * sy * sz;
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(64'd30_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule
